@@ src/pfc_pkg.sv @@
// pfc_pkg: shared types, constants and helper functions for the pixel format converter
// no dependencies; imported by the interfaces and all pfc modules
`default_nettype none

package pfc_pkg;

	localparam int unsigned PIX_W = 32;
	localparam int unsigned CNT_W = 3;
	localparam int unsigned FMT_W = 3;
	localparam int unsigned APB_AW = 3;
	localparam int unsigned APB_DW = 32;

	// pixel formats, all with 8-bit channels
	typedef enum logic [FMT_W-1:0] {
		FMT_L8    = 3'd0,
		FMT_A8    = 3'd1,
		FMT_LA8   = 3'd2,
		FMT_R8    = 3'd3,
		FMT_RGB8  = 3'd4,
		FMT_BGR8  = 3'd5,
		FMT_RGBA8 = 3'd6,
		FMT_BGRA8 = 3'd7
	} fmt_t;

	// register indexes on the configuration port
	typedef enum logic {
		REG_SRC_FMT = 1'b0,
		REG_DST_FMT = 1'b1
	} reg_idx_t;

	// format pair handed from the register block to the datapath
	typedef struct packed {
		fmt_t src_fmt;
		fmt_t dst_fmt;
	} cfg_t;

	localparam logic [7:0]       ALPHA_OPAQUE = 8'hFF;
	localparam logic [PIX_W-1:0] PIX_ZERO     = '0;

	// bytes per pixel of a format
	function automatic logic [CNT_W-1:0] fmt_bytes(input fmt_t f);
		logic [CNT_W-1:0] n;
		case (f)
			FMT_L8, FMT_A8, FMT_R8:   n = 3'd1;
			FMT_LA8:                  n = 3'd2;
			FMT_RGB8, FMT_BGR8:       n = 3'd3;
			FMT_RGBA8, FMT_BGRA8:     n = 3'd4;
			default:                  n = 3'd4;
		endcase
		return n;
	endfunction

	// mask covering the low n bytes of a pixel
	function automatic logic [PIX_W-1:0] bytes_mask(input logic [CNT_W-1:0] n);
		logic [PIX_W-1:0] m;
		case (n)
			3'd1:    m = 32'h0000_00FF;
			3'd2:    m = 32'h0000_FFFF;
			3'd3:    m = 32'h00FF_FFFF;
			default: m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction

	function automatic logic is_quad(input fmt_t f);
		return (f == FMT_RGBA8) || (f == FMT_BGRA8);
	endfunction

	function automatic logic is_tri(input fmt_t f);
		return (f == FMT_RGB8) || (f == FMT_BGR8);
	endfunction

	function automatic logic is_lum(input fmt_t f);
		return (f == FMT_L8) || (f == FMT_R8);
	endfunction

endpackage

`default_nettype wire

@@ src/pfc_stream_if.sv @@
// pfc_in_if / pfc_out_if: valid/ready stream channels for source and destination pixels
// depends on pfc_pkg for the payload widths
`default_nettype none

interface pfc_in_if;
	import pfc_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_in;
	logic             last_in;

	modport source(output valid, output pixel_in, output last_in, input ready);
	modport sink(input valid, input pixel_in, input last_in, output ready);
endinterface

interface pfc_out_if;
	import pfc_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_out;
	logic [CNT_W-1:0] byte_count;
	logic             supported;
	logic             last_out;

	modport source(output valid, output pixel_out, output byte_count, output supported,
		output last_out, input ready);
	modport sink(input valid, input pixel_out, input byte_count, input supported,
		input last_out, output ready);
endinterface

`default_nettype wire

@@ src/pfc_cfg_regs.sv @@
// pfc_cfg_regs: APB-style register block holding the source and destination formats
// depends on pfc_pkg
`default_nettype none

module pfc_cfg_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [pfc_pkg::APB_AW-1:0]  paddr,
	input  wire logic [pfc_pkg::APB_DW-1:0]  pwdata,
	output logic      [pfc_pkg::APB_DW-1:0]  prdata,
	output logic                             pready,
	output pfc_pkg::cfg_t                    cfg
);
	import pfc_pkg::*;

	fmt_t     src_fmt_q;
	fmt_t     dst_fmt_q;
	reg_idx_t idx;
	logic     wr_en;

	// register index from the word address
	assign idx    = reg_idx_t'(paddr[2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// format registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_fmt_q <= FMT_L8;
			dst_fmt_q <= FMT_L8;
		end else if (wr_en) begin
			case (idx)
				REG_SRC_FMT: src_fmt_q <= fmt_t'(pwdata[FMT_W-1:0]);
				REG_DST_FMT: dst_fmt_q <= fmt_t'(pwdata[FMT_W-1:0]);
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		case (idx)
			REG_SRC_FMT: prdata[FMT_W-1:0] = src_fmt_q;
			REG_DST_FMT: prdata[FMT_W-1:0] = dst_fmt_q;
			default:     prdata = '0;
		endcase
	end

	assign cfg.src_fmt = src_fmt_q;
	assign cfg.dst_fmt = dst_fmt_q;

endmodule

`default_nettype wire

@@ src/pfc_convert.sv @@
// pfc_convert: combinational byte shuffle from one pixel format to another
// depends on pfc_pkg
`default_nettype none

module pfc_convert (
	input  wire pfc_pkg::cfg_t              cfg,
	input  wire logic [pfc_pkg::PIX_W-1:0]  pixel,
	output logic      [pfc_pkg::PIX_W-1:0]  result,
	output logic      [pfc_pkg::CNT_W-1:0]  byte_count,
	output logic                            supported
);
	import pfc_pkg::*;

	fmt_t             s;
	fmt_t             d;
	logic [PIX_W-1:0] p;
	logic [7:0]       b0, b1, b2, b3;
	logic [PIX_W-1:0] r;
	logic             ok;

	assign s  = cfg.src_fmt;
	assign d  = cfg.dst_fmt;

	// bytes beyond the source size are ignored
	assign p  = pixel & bytes_mask(fmt_bytes(s));
	assign b0 = p[7:0];
	assign b1 = p[15:8];
	assign b2 = p[23:16];
	assign b3 = p[31:24];

	// conversion table, first match wins
	always_comb begin
		ok = 1'b1;
		r  = PIX_ZERO;
		if (s == FMT_L8 && d == FMT_LA8)
			r = {16'h0, b0, ALPHA_OPAQUE};
		else if (s == FMT_LA8 && d == FMT_L8)
			r = {24'h0, b1};
		else if (s == FMT_A8 && d == FMT_LA8)
			r = {16'h0, ALPHA_OPAQUE, b0};
		else if (s == FMT_LA8 && d == FMT_A8)
			r = {24'h0, b0};
		else if (is_lum(s) && is_quad(d))
			r = {ALPHA_OPAQUE, b0, b0, b0};
		else if (is_quad(s) && d == FMT_L8)
			r = {24'h0, b0};
		else if (is_lum(s) && is_tri(d))
			r = {8'h0, b0, b0, b0};
		else if (is_tri(s) && is_lum(d))
			r = {24'h0, b0};
		else if (s == FMT_A8 && is_quad(d))
			r = {b0, ALPHA_OPAQUE, ALPHA_OPAQUE, ALPHA_OPAQUE};
		else if (is_quad(s) && d == FMT_A8)
			r = {24'h0, b3};
		else if (s == FMT_LA8 && is_quad(d))
			r = {b1, b0, b0, b0};
		else if (is_quad(s) && d == FMT_LA8)
			r = {16'h0, b3, b0};
		else if ((s == FMT_RGB8 && d == FMT_RGBA8) || (s == FMT_BGR8 && d == FMT_BGRA8))
			r = {ALPHA_OPAQUE, b2, b1, b0};
		else if ((s == FMT_RGBA8 && d == FMT_RGB8) || (s == FMT_BGRA8 && d == FMT_BGR8))
			r = {8'h0, b2, b1, b0};
		else if ((s == FMT_RGB8 && d == FMT_BGRA8) || (s == FMT_BGR8 && d == FMT_RGBA8))
			r = {ALPHA_OPAQUE, b0, b1, b2};
		else if ((s == FMT_BGRA8 && d == FMT_RGB8) || (s == FMT_RGBA8 && d == FMT_BGR8))
			r = {8'h0, b0, b1, b2};
		else if (is_tri(s) && is_tri(d) && s != d)
			r = {8'h0, b0, b1, b2};
		else if (is_quad(s) && is_quad(d) && s != d)
			r = {b3, b0, b1, b2};
		else if (s == d)
			r = p;
		else
			ok = 1'b0;
	end

	// clip to the destination size; unsupported pairs give zero
	assign byte_count = fmt_bytes(d);
	assign result     = ok ? (r & bytes_mask(fmt_bytes(d))) : PIX_ZERO;
	assign supported  = ok;

endmodule

`default_nettype wire

@@ src/pixel_format_converter.sv @@
// pixel_format_converter: top level, input register, conversion logic and result register
// depends on pfc_pkg, pfc_in_if, pfc_out_if, pfc_cfg_regs and pfc_convert
`default_nettype none

// Converts one packed pixel per item between L8, A8, LA8, R8, RGB8, BGR8, RGBA8 and BGRA8
// (byte 0 in bits 7:0). Formats are set through the APB port: source format at address 0,
// destination format at address 4; change them only while no item is in flight. Each item
// passes through the input register, then the result register after the byte shuffle, and
// the block accepts one item per cycle, stalling only when both registers are full and the
// output is not taken. Unsupported format pairs give a zero pixel with supported low;
// byte_count always reflects the destination format.
module pixel_format_converter (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [pfc_pkg::APB_AW-1:0]  paddr,
	input  wire logic [pfc_pkg::APB_DW-1:0]  pwdata,
	output logic      [pfc_pkg::APB_DW-1:0]  prdata,
	output logic                             pready,
	pfc_in_if.sink                           pix_in,
	pfc_out_if.source                        pix_out
);
	import pfc_pkg::*;

	cfg_t             cfg;
	logic             valid_s1;
	logic [PIX_W-1:0] pixel_s1;
	logic             last_s1;
	logic             valid_s2;
	logic [PIX_W-1:0] pixel_s2;
	logic [CNT_W-1:0] count_s2;
	logic             supp_s2;
	logic             last_s2;
	logic             adv_s2;
	logic             adv_s1;
	logic [PIX_W-1:0] conv_pixel;
	logic [CNT_W-1:0] conv_count;
	logic             conv_supp;

	// configuration registers
	pfc_cfg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// stage flow control: a stage loads when it is empty or its item moves on
	assign adv_s2       = !valid_s2 || pix_out.ready;
	assign adv_s1       = !valid_s1 || adv_s2;
	assign pix_in.ready = adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= pix_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && pix_in.valid) begin
			pixel_s1 <= pix_in.pixel_in;
			last_s1  <= pix_in.last_in;
		end
	end

	// byte shuffle
	pfc_convert u_conv (
		.cfg        (cfg),
		.pixel      (pixel_s1),
		.result     (conv_pixel),
		.byte_count (conv_count),
		.supported  (conv_supp)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			pixel_s2 <= conv_pixel;
			count_s2 <= conv_count;
			supp_s2  <= conv_supp;
			last_s2  <= last_s1;
		end
	end

	assign pix_out.valid      = valid_s2;
	assign pix_out.pixel_out  = pixel_s2;
	assign pix_out.byte_count = count_s2;
	assign pix_out.supported  = supp_s2;
	assign pix_out.last_out   = last_s2;

`ifndef SYNTH
	// a held item in the input register is not dropped while the output stalls
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !pix_out.ready |=> valid_s1)
		else $error("input register lost an item during stall");

	// unsupported pairs always give a zero pixel
	a_unsup_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !supp_s2 |-> pixel_s2 == PIX_ZERO)
		else $error("unsupported pair gave a nonzero pixel");

	// byte count stays in its range
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (count_s2 == 3'd1 || count_s2 == 3'd2 || count_s2 == 3'd3 ||
			count_s2 == 3'd4))
		else $error("byte count out of range");

	// bytes beyond a single-byte destination are zero
	a_high_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && count_s2 == 3'd1 |-> pixel_s2[31:8] == 24'h0)
		else $error("single byte pixel has stray high bytes");

	// an item taken at the input lands in the input register
	a_load_s1: assert property (@(posedge clk) disable iff (!arst_n)
		pix_in.valid && pix_in.ready |=> valid_s1)
		else $error("accepted item missing from input register");
`endif

endmodule

`default_nettype wire

@@ tb/sv/pfc_tb_pkg.sv @@
`timescale 1ns / 100ps
// pfc_tb_pkg: scoreboard for the pixel format converter testbench, predicts each output item
// from the current format pair and checks results in order; depends on pfc_pkg
package pfc_tb_pkg;
	import pfc_pkg::*;

	localparam logic [7:0] OPAQUE = 8'hFF;

	// one destination pixel as the block reports it
	typedef struct {
		logic [PIX_W-1:0] pixel;
		logic [CNT_W-1:0] count;
		logic             ok;
		logic             last;
	} pixel_result_t;

	class conversion_checker;
		fmt_t          src_fmt;
		fmt_t          dst_fmt;
		pixel_result_t expected_pixels[$];
		int unsigned   fail_count;

		function new();
			src_fmt = FMT_L8;
			dst_fmt = FMT_L8;
			fail_count = 0;
		endfunction

		function void set_format(reg_idx_t idx, fmt_t f);
			if (idx == REG_SRC_FMT) begin
				src_fmt = f;
			end else begin
				dst_fmt = f;
			end
		endfunction

		function logic [CNT_W-1:0] width_of(fmt_t f);
			case (f)
				FMT_LA8:              return 3'd2;
				FMT_RGB8, FMT_BGR8:   return 3'd3;
				FMT_RGBA8, FMT_BGRA8: return 3'd4;
				default:              return 3'd1;
			endcase
		endfunction

		function logic [PIX_W-1:0] low_bytes(logic [CNT_W-1:0] n);
			return (n >= 3'd4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * n)) - 32'd1);
		endfunction

		function bit rgba_like(fmt_t f);
			return f == FMT_RGBA8 || f == FMT_BGRA8;
		endfunction

		function bit rgb_like(fmt_t f);
			return f == FMT_RGB8 || f == FMT_BGR8;
		endfunction

		function bit gray_like(fmt_t f);
			return f == FMT_L8 || f == FMT_R8;
		endfunction

		// expected destination pixel for one source pixel under the current formats
		function pixel_result_t convert(logic [PIX_W-1:0] raw, logic lst);
			fmt_t             s;
			fmt_t             d;
			logic [PIX_W-1:0] p;
			logic [PIX_W-1:0] r;
			logic [7:0]       b0, b1, b2, b3;
			logic             ok;
			pixel_result_t    res;
			s = src_fmt;
			d = dst_fmt;
			p = raw & low_bytes(width_of(s));
			{b3, b2, b1, b0} = p;
			ok = 1'b1;
			r = '0;
			if (s == FMT_L8 && d == FMT_LA8) r = {16'h0, b0, OPAQUE};
			else if (s == FMT_LA8 && d == FMT_L8) r = {24'h0, b1};
			else if (s == FMT_A8 && d == FMT_LA8) r = {16'h0, OPAQUE, b0};
			else if (s == FMT_LA8 && d == FMT_A8) r = {24'h0, b0};
			else if (gray_like(s) && rgba_like(d)) r = {OPAQUE, b0, b0, b0};
			else if (rgba_like(s) && d == FMT_L8) r = {24'h0, b0};
			else if (gray_like(s) && rgb_like(d)) r = {8'h0, b0, b0, b0};
			else if (rgb_like(s) && gray_like(d)) r = {24'h0, b0};
			else if (s == FMT_A8 && rgba_like(d)) r = {b0, OPAQUE, OPAQUE, OPAQUE};
			else if (rgba_like(s) && d == FMT_A8) r = {24'h0, b3};
			else if (s == FMT_LA8 && rgba_like(d)) r = {b1, b0, b0, b0};
			else if (rgba_like(s) && d == FMT_LA8) r = {16'h0, b3, b0};
			else if ((s == FMT_RGB8 && d == FMT_RGBA8) || (s == FMT_BGR8 && d == FMT_BGRA8))
				r = {OPAQUE, b2, b1, b0};
			else if ((s == FMT_RGBA8 && d == FMT_RGB8) || (s == FMT_BGRA8 && d == FMT_BGR8))
				r = {8'h0, b2, b1, b0};
			else if ((s == FMT_RGB8 && d == FMT_BGRA8) || (s == FMT_BGR8 && d == FMT_RGBA8))
				r = {OPAQUE, b0, b1, b2};
			else if ((s == FMT_BGRA8 && d == FMT_RGB8) || (s == FMT_RGBA8 && d == FMT_BGR8))
				r = {8'h0, b0, b1, b2};
			else if (rgb_like(s) && rgb_like(d) && s != d) r = {8'h0, b0, b1, b2};
			else if (rgba_like(s) && rgba_like(d) && s != d) r = {b3, b0, b1, b2};
			else if (s == d) r = p;
			else ok = 1'b0;
			res.pixel = ok ? (r & low_bytes(width_of(d))) : '0;
			res.count = width_of(d);
			res.ok = ok;
			res.last = lst;
			return res;
		endfunction

		function void note_pixel(logic [PIX_W-1:0] raw, logic lst);
			expected_pixels.push_back(convert(raw, lst));
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction

		function void check_pixel(pixel_result_t got);
			pixel_result_t want;
			if (expected_pixels.size() == 0) begin
				$error("output item with nothing expected: pixel_out %h", got.pixel);
				fail_count++;
				return;
			end
			want = expected_pixels.pop_front();
			if (got.pixel !== want.pixel) begin
				$error("pixel_out: expected %h, actual %h", want.pixel, got.pixel);
				fail_count++;
			end
			if (got.count !== want.count) begin
				$error("byte_count: expected %0d, actual %0d", want.count, got.count);
				fail_count++;
			end
			if (got.ok !== want.ok) begin
				$error("supported: expected %b, actual %b", want.ok, got.ok);
				fail_count++;
			end
			if (got.last !== want.last) begin
				$error("last_out: expected %b, actual %b", want.last, got.last);
				fail_count++;
			end
		endfunction
	endclass

endpackage

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// testbench: drives pixel_format_converter through directed pixels and every format pair
// with random pixels and random stalls; depends on pfc_pkg, the stream interfaces, pfc_tb_pkg
module testbench;
	import pfc_pkg::*;
	import pfc_tb_pkg::*;

	localparam int ITEMS_PER_PAIR = 18;
	localparam int SETTLE_CYCLES  = 4;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	int unsigned       send_idle_pct;
	int unsigned       recv_idle_pct;

	conversion_checker conv_sb = new();

	pfc_in_if  pix_in_ch();
	pfc_out_if pix_out_ch();

	pixel_format_converter u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pix_in  (pix_in_ch),
		.pix_out (pix_out_ch)
	);

	// 10 ns clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop if the run hangs
	initial begin
		#3_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// output side: random stalls, check every accepted item
	initial begin : receive_items
		pixel_result_t got;
		pix_out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			pix_out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
			@(posedge clk);
			if (arst_n && pix_out_ch.valid && pix_out_ch.ready) begin
				got.pixel = pix_out_ch.pixel_out;
				got.count = pix_out_ch.byte_count;
				got.ok = pix_out_ch.supported;
				got.last = pix_out_ch.last_out;
				conv_sb.check_pixel(got);
			end
		end
	end

	// apb write of one format register, called at a falling edge
	task automatic write_format(input reg_idx_t idx, input fmt_t f);
		logic [APB_DW-1:0] noise;
		noise = $urandom();
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = {noise[APB_DW-1:FMT_W], f};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		conv_sb.set_format(idx, f);
	endtask

	// hold the input until every expected item is out and the pipeline is empty
	task automatic drain();
		pix_in_ch.valid = 1'b0;
		while (conv_sb.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// switch format pair, only with the block idle
	task automatic set_pair(input fmt_t s, input fmt_t d);
		if (s != conv_sb.src_fmt || d != conv_sb.dst_fmt) begin
			drain();
			if (s != conv_sb.src_fmt) write_format(REG_SRC_FMT, s);
			if (d != conv_sb.dst_fmt) write_format(REG_DST_FMT, d);
		end
	endtask

	// offer one pixel item, with random idle cycles ahead of it
	task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic lst);
		while ($urandom_range(99) < send_idle_pct) begin
			pix_in_ch.valid = 1'b0;
			@(negedge clk);
		end
		pix_in_ch.valid = 1'b1;
		pix_in_ch.pixel_in = pix;
		pix_in_ch.last_in = lst;
		do @(posedge clk); while (!pix_in_ch.ready);
		conv_sb.note_pixel(pix, lst);
		@(negedge clk);
	endtask

	initial begin : stimulus
		int               order[64];
		int               k;
		int               j;
		int               b;
		int               tmp;
		logic [5:0]       pair_code;
		logic [PIX_W-1:0] pix;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pix_in_ch.valid = 1'b0;
		pix_in_ch.pixel_in = '0;
		pix_in_ch.last_in = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset formats: L8 pass-through, high bytes dropped
		send_pixel(32'h0000_0000, 1'b0);
		send_pixel(32'hFFFF_FFFF, 1'b1);
		send_pixel(32'hA5C3_3C5A, 1'b0);
		// luminance gains and loses alpha
		set_pair(FMT_L8, FMT_LA8);
		send_pixel(32'hDEAD_BE5A, 1'b0);
		send_pixel(32'hFFFF_FFFF, 1'b1);
		set_pair(FMT_LA8, FMT_L8);
		send_pixel(32'h1234_C3A7, 1'b0);
		send_pixel(32'hFFFF_FFFF, 1'b1);
		// red/blue swaps
		set_pair(FMT_RGB8, FMT_BGRA8);
		send_pixel(32'h0012_3456, 1'b0);
		send_pixel(32'hFFFF_FFFF, 1'b0);
		set_pair(FMT_RGBA8, FMT_BGRA8);
		send_pixel(32'h8040_2010, 1'b1);
		send_pixel(32'h0000_0000, 1'b0);
		// equal four-byte formats
		set_pair(FMT_BGRA8, FMT_BGRA8);
		send_pixel(32'hFFFF_FFFF, 1'b0);
		send_pixel(32'h0123_4567, 1'b1);
		// unsupported pairs give a zero pixel
		set_pair(FMT_A8, FMT_L8);
		send_pixel(32'hFFFF_FFFF, 1'b0);
		send_pixel(32'h1234_5678, 1'b1);
		set_pair(FMT_RGBA8, FMT_R8);
		send_pixel(32'h1122_3344, 1'b0);
		// alpha only into rgba, and rgba out to luminance plus alpha
		set_pair(FMT_A8, FMT_RGBA8);
		send_pixel(32'h0000_00C8, 1'b0);
		send_pixel(32'hFFFF_FF00, 1'b1);
		set_pair(FMT_RGBA8, FMT_LA8);
		send_pixel(32'h7F00_00AA, 1'b0);

		// every format pair once, in random order
		for (k = 0; k < 64; k++) order[k] = k;
		for (k = 63; k > 0; k--) begin
			j = $urandom_range(k);
			tmp = order[k];
			order[k] = order[j];
			order[j] = tmp;
		end
		for (k = 0; k < 64; k++) begin
			if (k < 22) begin
				send_idle_pct = 25;
				recv_idle_pct = 81;
			end else if (k < 43) begin
				send_idle_pct = 81;
				recv_idle_pct = 25;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			pair_code = order[k][5:0];
			set_pair(fmt_t'(pair_code[5:3]), fmt_t'(pair_code[2:0]));
			for (j = 0; j < ITEMS_PER_PAIR; j++) begin
				// let the output run dry once in the middle of a pair
				if (k == 30 && j == 9) drain();
				case ($urandom_range(3))
					0: begin
						for (b = 0; b < 4; b++) begin
							case ($urandom_range(2))
								0:       pix[8*b +: 8] = 8'h00;
								1:       pix[8*b +: 8] = 8'hFF;
								default: pix[8*b +: 8] = 8'($urandom_range(255));
							endcase
						end
					end
					1:       pix = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
					default: pix = $urandom();
				endcase
				send_pixel(pix, $urandom_range(7) == 0);
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (conv_sb.fail_count == 0 && conv_sb.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
